@@ design/kmc_pkg.sv @@
`timescale 1ns / 1ps
package kmc_pkg;
  localparam int MaxVertices = 64;
  localparam int MaxEdges = 2048;
  localparam int WeightBits = 16;
  localparam int VBits = 6;
  localparam int EBits = 11;
  localparam int CountBits = 12;
  localparam int CostBits = 22;
  localparam int EntryBits = 2 * VBits + WeightBits;

  localparam logic [1:0] RegVertexCount = 2'd0;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_CLEAR,
    ST_SORT_RD,
    ST_SORT_CMP,
    ST_SORT_WR,
    ST_MST_RD,
    ST_MST_WAIT,
    ST_FIND_RD,
    ST_FIND,
    ST_COMP_RD,
    ST_COMPRESS,
    ST_JOIN,
    ST_NEXT,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic [VBits-1:0] end_a;
    logic [VBits-1:0] end_b;
    logic [WeightBits-1:0] weight;
  } edge_t;
endpackage

@@ design/kmc_if.sv @@
`timescale 1ns / 1ps
interface kmc_edge_if (input logic clk);
  logic valid;
  logic ready;
  logic [kmc_pkg::VBits-1:0] end_a;
  logic [kmc_pkg::VBits-1:0] end_b;
  logic [kmc_pkg::WeightBits-1:0] weight;
  logic last_edge;
  modport source(output valid, end_a, end_b, weight, last_edge, input ready);
  modport sink(input valid, end_a, end_b, weight, last_edge, output ready);
endinterface

interface kmc_cost_if (input logic clk);
  logic valid;
  logic ready;
  logic [kmc_pkg::CostBits-1:0] total_cost;
  logic dropped;
  modport source(output valid, total_cost, dropped, input ready);
  modport sink(input valid, total_cost, dropped, output ready);
endinterface

@@ design/kmc_ram.sv @@
`timescale 1ns / 1ps
module kmc_ram #(
  parameter int Width = 28,
  parameter int Depth = 2048,
  parameter int ABits = 11
) (
  input  logic             clk,
  input  logic             we,
  input  logic [ABits-1:0] waddr,
  input  logic [Width-1:0] wdata,
  input  logic [ABits-1:0] raddr,
  output logic [Width-1:0] rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ design/kruskal_mst_cost.sv @@
`timescale 1ns / 1ps
// Edges load at one beat per cycle into the edge memory while the block is loading.
// After the last edge: a clear of all 64 sets, an insertion sort of the stored
// edges by weight with element shifts, then per sorted edge the two root walks,
// compression and join on the union-find tables.
// The result beat follows; the next graph is taken once it is delivered.
// Synchronous active-high reset: empty store, vertex count 64; sets clear per run.
module kruskal_mst_cost (
  input  logic            clk,
  input  logic            rst,
  kmc_edge_if.sink        edge_in,
  kmc_cost_if.source      cost_out,
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [1:0]      paddr,
  input  logic [31:0]     pwdata,
  output logic [31:0]     prdata,
  output logic            pready
);
  localparam int VB = kmc_pkg::VBits;
  localparam int EB = kmc_pkg::EBits;
  localparam int CB = kmc_pkg::CountBits;

  kmc_pkg::state_t state, state_next;
  logic [6:0] vertex_count;
  logic [CB-1:0] edge_count;
  logic drop_flag;
  logic [kmc_pkg::CostBits-1:0] cost_sum;
  logic [VB-1:0] parent [kmc_pkg::MaxVertices];
  logic [2:0] rank [kmc_pkg::MaxVertices];

  // Sort and walk state.
  logic [CB-1:0] i_idx, j_idx;
  kmc_pkg::edge_t key;
  logic [VB-1:0] cur, root_a, start_v;
  logic side;
  logic [VB:0] clr;
  kmc_pkg::edge_t cur_edge;
  logic [VB-1:0] root_b;

  // Registered reads of the union-find tables and their write ports.
  logic [VB-1:0] par_q;
  logic [2:0] rank_qa, rank_qb;
  logic par_we, rank_we;
  logic [VB-1:0] par_waddr, par_wdata, rank_waddr;
  logic [2:0] rank_wdata;

  // Edge memory in arrival order.
  logic e_we;
  logic [EB-1:0] e_waddr, e_raddr;
  kmc_pkg::edge_t e_wdata, e_rdata;
  logic [CB-1:0] i_plus;

  kmc_ram #(.Width(kmc_pkg::EntryBits), .Depth(kmc_pkg::MaxEdges), .ABits(EB)) u_edges (
    .clk, .we(e_we), .waddr(e_waddr), .wdata(e_wdata), .raddr(e_raddr), .rdata(e_rdata));

  // Sorted copy holds full entries so the walk needs one read per edge.
  logic s_we;
  logic [EB-1:0] s_waddr, s_raddr;
  kmc_pkg::edge_t s_wdata, s_rdata;
  kmc_ram #(.Width(kmc_pkg::EntryBits), .Depth(kmc_pkg::MaxEdges), .ABits(EB)) u_sorted (
    .clk, .we(s_we), .waddr(s_waddr), .wdata(s_wdata), .raddr(s_raddr), .rdata(s_rdata));

  logic [6:0] nv;
  logic bad;
  logic acc;
  assign nv = (vertex_count > 7'(kmc_pkg::MaxVertices)) ? 7'(kmc_pkg::MaxVertices)
                                                         : vertex_count;
  assign bad = ({1'b0, edge_in.end_a} >= nv) || ({1'b0, edge_in.end_b} >= nv) ||
               (edge_count >= CB'(kmc_pkg::MaxEdges));
  assign edge_in.ready = (state == kmc_pkg::ST_LOAD);
  assign acc = edge_in.valid && edge_in.ready;
  assign pready = 1'b1;
  assign prdata = (paddr == kmc_pkg::RegVertexCount) ? {25'd0, vertex_count} : 32'd0;
  assign cost_out.valid = (state == kmc_pkg::ST_OUT);
  assign cost_out.total_cost = cost_sum;
  assign cost_out.dropped = drop_flag;
  assign i_plus = i_idx + CB'(1);

  // Insertion sort runs on the sorted memory directly: j walks down from i.
  assign e_we = acc && !bad;
  assign e_waddr = edge_count[EB-1:0];
  assign e_wdata = '{end_a: edge_in.end_a, end_b: edge_in.end_b, weight: edge_in.weight};
  assign e_raddr = i_idx[EB-1:0];

  logic [CB-1:0] j_m1;
  assign j_m1 = j_idx - CB'(1);
  assign s_raddr = (state == kmc_pkg::ST_MST_RD) ? i_idx[EB-1:0] : j_m1[EB-1:0];

  logic cmp_gt;
  assign cmp_gt = s_rdata.weight > key.weight;

  always_comb begin
    state_next = state;
    unique case (state)
      kmc_pkg::ST_LOAD: if (acc && edge_in.last_edge) state_next = kmc_pkg::ST_CLEAR;
      kmc_pkg::ST_CLEAR: if (clr == (VB+1)'(kmc_pkg::MaxVertices - 1))
                           state_next = kmc_pkg::ST_SORT_RD;
      kmc_pkg::ST_SORT_RD:
        if (i_idx >= edge_count) state_next = kmc_pkg::ST_MST_RD;
        else state_next = kmc_pkg::ST_SORT_CMP;
      kmc_pkg::ST_SORT_CMP: state_next = kmc_pkg::ST_SORT_WR;
      kmc_pkg::ST_SORT_WR:
        if (j_idx != '0 && cmp_gt) state_next = kmc_pkg::ST_SORT_CMP;
        else state_next = kmc_pkg::ST_SORT_RD;
      kmc_pkg::ST_MST_RD:
        if (i_idx >= edge_count) state_next = kmc_pkg::ST_OUT;
        else state_next = kmc_pkg::ST_MST_WAIT;
      kmc_pkg::ST_MST_WAIT: state_next = kmc_pkg::ST_FIND_RD;
      kmc_pkg::ST_FIND_RD: state_next = kmc_pkg::ST_FIND;
      kmc_pkg::ST_FIND:
        if (par_q == cur) state_next = kmc_pkg::ST_COMP_RD;
        else state_next = kmc_pkg::ST_FIND_RD;
      kmc_pkg::ST_COMP_RD: state_next = kmc_pkg::ST_COMPRESS;
      kmc_pkg::ST_COMPRESS:
        if (par_q == root_a || cur == root_a) begin
          state_next = side ? kmc_pkg::ST_JOIN : kmc_pkg::ST_FIND_RD;
        end else begin
          state_next = kmc_pkg::ST_COMP_RD;
        end
      kmc_pkg::ST_JOIN: state_next = kmc_pkg::ST_NEXT;
      kmc_pkg::ST_NEXT: state_next = kmc_pkg::ST_MST_RD;
      kmc_pkg::ST_OUT: if (cost_out.ready) state_next = kmc_pkg::ST_LOAD;
      default: state_next = kmc_pkg::ST_LOAD;
    endcase
  end

  // Write port of the sorted memory: shift during compare, key on exit.
  always_comb begin
    s_we = 1'b0;
    s_waddr = j_idx[EB-1:0];
    s_wdata = key;
    if (state == kmc_pkg::ST_SORT_WR) begin
      s_we = 1'b1;
      if (j_idx != '0 && cmp_gt) s_wdata = s_rdata;
    end
  end

  // Write ports of the union-find tables.
  always_comb begin
    par_we = 1'b0;
    par_waddr = cur;
    par_wdata = root_a;
    rank_we = 1'b0;
    rank_waddr = root_b;
    rank_wdata = rank_qb + 3'd1;
    unique case (state)
      kmc_pkg::ST_CLEAR: begin
        par_we = 1'b1;
        par_waddr = clr[VB-1:0];
        par_wdata = clr[VB-1:0];
        rank_we = 1'b1;
        rank_waddr = clr[VB-1:0];
        rank_wdata = '0;
      end
      kmc_pkg::ST_COMPRESS: par_we = !(par_q == root_a || cur == root_a);
      kmc_pkg::ST_JOIN: begin
        // root_b holds the first endpoint's root, root_a the second's.
        if (root_b != root_a) begin
          par_we = 1'b1;
          if (rank_qb < rank_qa) begin
            par_waddr = root_b;
            par_wdata = root_a;
          end else begin
            par_waddr = root_a;
            par_wdata = root_b;
            rank_we = (rank_qa == rank_qb);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (par_we) begin
      parent[par_waddr] <= par_wdata;
    end
    if (rank_we) begin
      rank[rank_waddr] <= rank_wdata;
    end
    par_q <= parent[cur];
    rank_qa <= rank[root_a];
    rank_qb <= rank[root_b];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= kmc_pkg::ST_LOAD;
      vertex_count <= 7'd64;
      edge_count <= '0;
      drop_flag <= 1'b0;
      cost_sum <= '0;
      clr <= '0;
      i_idx <= '0;
    end else begin
      state <= state_next;
      if (psel && penable && pwrite && paddr == kmc_pkg::RegVertexCount) begin
        vertex_count <= pwdata[6:0];
      end
      unique case (state)
        kmc_pkg::ST_LOAD: begin
          if (acc) begin
            if (bad) drop_flag <= 1'b1;
            else edge_count <= edge_count + CB'(1);
          end
          clr <= '0;
          i_idx <= '0;
          cost_sum <= (acc && edge_in.last_edge) ? '0 : cost_sum;
        end
        kmc_pkg::ST_CLEAR: clr <= clr + (VB+1)'(1);
        kmc_pkg::ST_SORT_RD: begin
          j_idx <= i_idx;
          if (i_idx >= edge_count) i_idx <= '0;
        end
        kmc_pkg::ST_SORT_CMP: key <= (j_idx == i_idx) ? e_rdata : key;
        kmc_pkg::ST_SORT_WR: begin
          if (j_idx != '0 && cmp_gt) j_idx <= j_m1;
          else i_idx <= i_plus;
        end
        kmc_pkg::ST_MST_RD: ;
        kmc_pkg::ST_MST_WAIT: begin
          cur_edge <= s_rdata;
          cur <= s_rdata.end_a;
          start_v <= s_rdata.end_a;
          side <= 1'b0;
        end
        kmc_pkg::ST_FIND: begin
          if (par_q == cur) begin
            root_a <= cur;
            cur <= start_v;
          end else begin
            cur <= par_q;
          end
        end
        kmc_pkg::ST_COMPRESS: begin
          if (par_q == root_a || cur == root_a) begin
            if (!side) begin
              root_b <= root_a;
              cur <= cur_edge.end_b;
              start_v <= cur_edge.end_b;
              side <= 1'b1;
            end
          end else begin
            cur <= par_q;
          end
        end
        kmc_pkg::ST_JOIN: begin
          if (root_b != root_a) begin
            cost_sum <= cost_sum + kmc_pkg::CostBits'(cur_edge.weight);
          end
        end
        kmc_pkg::ST_NEXT: i_idx <= i_plus;
        kmc_pkg::ST_OUT: begin
          if (cost_out.ready) begin
            edge_count <= '0;
            drop_flag <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_ready_load: assert property (@(posedge clk) disable iff (rst)
    edge_in.ready |-> !cost_out.valid) else $error("ready during result");
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    edge_count <= CB'(kmc_pkg::MaxEdges)) else $error("edge count overflow");
  a_out_clear: assert property (@(posedge clk) disable iff (rst)
    cost_out.valid && cost_out.ready |=> edge_count == '0 && !drop_flag)
    else $error("state not cleared after result");
`endif
endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps
module tb;
  typedef struct {
    logic [kmc_pkg::VBits-1:0] end_a;
    logic [kmc_pkg::VBits-1:0] end_b;
    logic [kmc_pkg::WeightBits-1:0] weight;
  } stored_edge_t;

  typedef struct {
    logic [kmc_pkg::CostBits-1:0] total_cost;
    logic dropped;
  } forest_result_t;

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  kmc_edge_if edge_in (clk);
  kmc_cost_if cost_out (clk);

  kruskal_mst_cost dut (
    .clk(clk),
    .rst(rst),
    .edge_in(edge_in.sink),
    .cost_out(cost_out.source),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  // Predictor state for the graph being loaded.
  stored_edge_t graph_edges[$];
  bit graph_dropped;
  int unsigned vertex_limit;
  forest_result_t pending_costs[$];

  int mismatches;
  int idle_cycles;
  int hold_cycles;
  bit random_stall;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int unsigned find_set(ref int unsigned parent[kmc_pkg::MaxVertices],
                                           input int unsigned v);
    int unsigned root;
    int unsigned nxt;
    root = v;
    while (parent[root] != root) root = parent[root];
    while (parent[v] != root) begin
      nxt = parent[v];
      parent[v] = root;
      v = nxt;
    end
    return root;
  endfunction

  function automatic logic [kmc_pkg::CostBits-1:0] forest_weight();
    stored_edge_t ordered[$];
    int unsigned parent[kmc_pkg::MaxVertices];
    int unsigned rank_of[kmc_pkg::MaxVertices];
    int unsigned ra;
    int unsigned rb;
    int j;
    logic [kmc_pkg::CostBits-1:0] total;
    total = '0;
    // Stable insertion: ties keep arrival order.
    foreach (graph_edges[i]) begin
      j = ordered.size();
      while (j > 0 && ordered[j-1].weight > graph_edges[i].weight) j--;
      ordered.insert(j, graph_edges[i]);
    end
    for (int v = 0; v < kmc_pkg::MaxVertices; v++) begin
      parent[v] = v;
      rank_of[v] = 0;
    end
    foreach (ordered[i]) begin
      ra = find_set(parent, ordered[i].end_a);
      rb = find_set(parent, ordered[i].end_b);
      if (ra != rb) begin
        if (rank_of[ra] < rank_of[rb]) begin
          parent[ra] = rb;
        end else if (rank_of[rb] < rank_of[ra]) begin
          parent[rb] = ra;
        end else begin
          parent[rb] = ra;
          rank_of[ra]++;
        end
        total = total + ordered[i].weight;
      end
    end
    return total;
  endfunction

  function automatic void predict_edge(logic [kmc_pkg::VBits-1:0] a,
                                       logic [kmc_pkg::VBits-1:0] b,
                                       logic [kmc_pkg::WeightBits-1:0] w, logic last);
    int unsigned nv;
    stored_edge_t e;
    forest_result_t r;
    nv = (vertex_limit > kmc_pkg::MaxVertices) ? kmc_pkg::MaxVertices : vertex_limit;
    if (a >= nv || b >= nv || graph_edges.size() >= kmc_pkg::MaxEdges) begin
      graph_dropped = 1'b1;
    end else begin
      e.end_a = a;
      e.end_b = b;
      e.weight = w;
      graph_edges.insert(graph_edges.size(), e);
    end
    if (last) begin
      r.total_cost = forest_weight();
      r.dropped = graph_dropped;
      pending_costs.insert(pending_costs.size(), r);
      graph_edges.delete();
      graph_dropped = 1'b0;
    end
  endfunction

  // Valid stays high after a beat; it drops only when a gap or a drain follows.
  task automatic send_edge(int a, int b, int w, bit last, bit no_gap = 0);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 15);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      edge_in.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    edge_in.valid <= 1'b1;
    edge_in.end_a <= kmc_pkg::VBits'(a);
    edge_in.end_b <= kmc_pkg::VBits'(b);
    edge_in.weight <= kmc_pkg::WeightBits'(w);
    edge_in.last_edge <= last;
    @(posedge clk);
    while (!edge_in.ready) @(posedge clk);
    predict_edge(kmc_pkg::VBits'(a), kmc_pkg::VBits'(b), kmc_pkg::WeightBits'(w), last);
  endtask

  task automatic write_vertex_count(int unsigned value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= kmc_pkg::RegVertexCount;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    vertex_limit = value & 32'h7F;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic drain();
    edge_in.valid <= 1'b0;
    while (pending_costs.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic send_graph(int n, int nv_span, bit loaded = 0);
    int a;
    int b;
    for (int i = 0; i < n; i++) begin
      if (!loaded && $urandom_range(0, 19) == 0) begin
        a = $urandom_range(0, 63);
        b = $urandom_range(0, 63);
      end else begin
        a = $urandom_range(0, nv_span - 1);
        b = $urandom_range(0, nv_span - 1);
      end
      send_edge(a, b, $urandom_range(0, 15) == 0 ? $urandom_range(0, 3) : $urandom(),
                i == n - 1, loaded);
    end
  endtask

  task automatic test_directed();
    send_edge(0, 63, 16'hFFFF, 0);
    send_edge(63, 0, 16'hFFFF, 0);
    send_edge(5, 5, 7, 0);
    send_edge(1, 2, 0, 0);
    send_edge(2, 3, 16'h5555, 0);
    send_edge(3, 1, 16'hAAAA, 1);
    send_edge(4, 4, 9, 1);
    send_edge(0, 1, 3, 0);
    send_edge(1, 0, 3, 0);
    send_edge(0, 1, 1, 1);
    drain();
    write_vertex_count(4);
    send_edge(0, 3, 10, 0);
    send_edge(4, 1, 10, 0);
    send_edge(2, 1, 20, 0);
    send_edge(63, 2, 5, 1);
    drain();
    write_vertex_count(0);
    send_edge(0, 0, 1, 0);
    send_edge(0, 1, 1, 1);
    drain();
    write_vertex_count(127);
    send_edge(62, 63, 100, 0);
    send_edge(63, 0, 200, 1);
    drain();
    write_vertex_count(1);
    send_edge(0, 0, 5, 0);
    send_edge(0, 1, 5, 1);
    drain();
  endtask

  task automatic test_store_full();
    write_vertex_count(64);
    for (int i = 0; i < kmc_pkg::MaxEdges + 3; i++)
      send_edge($urandom_range(0, 63), $urandom_range(0, 63), 16'hFFFF - i[15:0],
                i == kmc_pkg::MaxEdges + 2, 1);
    drain();
  endtask

  task automatic test_backpressure();
    hold_cycles = 400;
    send_graph(6, 8);
    send_graph(5, 8, 1);
    send_graph(4, 8, 1);
    drain();
  endtask

  task automatic test_random();
    int sent;
    int n;
    int nv;
    sent = 0;
    while (sent < 1200) begin
      if ($urandom_range(0, 5) == 0) begin
        drain();
        nv = $urandom_range(0, 3) == 0 ? $urandom_range(0, 127) : $urandom_range(2, 64);
        write_vertex_count(nv);
      end
      nv = (vertex_limit > kmc_pkg::MaxVertices) ? kmc_pkg::MaxVertices : vertex_limit;
      n = $urandom_range(1, 30);
      if (nv == 0) send_graph(n, 1);
      else send_graph(n, nv);
      sent += n;
      random_stall = ($urandom_range(0, 3) != 0);
    end
    drain();
    write_vertex_count(64);
    drain();
  endtask

  // Receiver: random stalls, plus a long hold-off when one is requested.
  initial begin
    int gap;
    cost_out.ready = 1'b0;
    @(negedge rst);
    forever begin
      if (hold_cycles > 0) begin
        cost_out.ready <= 1'b0;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
      end
      gap = random_stall ? $urandom_range(0, 15) : 0;
      if (gap > 0) begin
        cost_out.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      cost_out.ready <= 1'b1;
      @(posedge clk);
    end
  end

  // Result checker.
  always @(posedge clk) begin
    forest_result_t exp_r;
    if (!rst && cost_out.valid && cost_out.ready) begin
      if (pending_costs.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: total_cost=%0d dropped=%0b",
                   cost_out.total_cost, cost_out.dropped);
      end else begin
        exp_r = pending_costs.pop_front();
        if (cost_out.total_cost !== exp_r.total_cost || cost_out.dropped !== exp_r.dropped) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: expected cost=%0d dropped=%0b, got cost=%0d dropped=%0b",
                     exp_r.total_cost, exp_r.dropped, cost_out.total_cost, cost_out.dropped);
        end
      end
    end
  end

  // Watchdog on cycles without any accepted beat; a full reverse-ordered store
  // is the longest sort that it has to wait out.
  always @(posedge clk) begin
    if ((edge_in.valid && edge_in.ready) || (cost_out.valid && cost_out.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000000) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    edge_in.valid = 1'b0;
    edge_in.end_a = '0;
    edge_in.end_b = '0;
    edge_in.weight = '0;
    edge_in.last_edge = 1'b0;
    vertex_limit = 64;
    graph_dropped = 1'b0;
    mismatches = 0;
    idle_cycles = 0;
    hold_cycles = 0;
    random_stall = 1'b1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_store_full();
    test_random();
    if (mismatches == 0 && pending_costs.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end
endmodule

@@ files.f @@
design/kmc_pkg.sv
design/kmc_if.sv
design/kmc_ram.sv
design/kruskal_mst_cost.sv
verif/tb.sv
